FILE: hdl/msps_pkg.sv
// msps_pkg: shared types, widths and codes for the motor speed pid step unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package msps_pkg;

    // field and datapath widths
    localparam int GainW  = 16;              // gains and speed scale, unsigned
    localparam int SpeedW = 16;              // target speed, rpm, drive value
    localparam int ErrW   = 18;              // error and previous error
    localparam int DiffW  = ErrW + 1;        // error minus previous error
    localparam int AccW   = 32;              // clamped error sum
    localparam int IlimW  = 31;              // integral limit
    localparam int OlimW  = 15;              // output limit
    localparam int OperW  = 32;              // serial multiplier operand
    localparam int MacW   = 50;              // product sum, holds all three terms
    localparam int FracSh = 8;               // q8.8 gain fraction bits
    localparam int ResW   = MacW - FracSh;   // product sum without the gain fraction
    localparam int FbSh   = 16;              // q0.16 speed scale fraction bits
    localparam int CntW   = $clog2(GainW + 1);
    localparam int AddrW  = 5;
    localparam int DataW  = 32;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4,
        REG_SPEED_SCALE    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [GainW-1:0] prop_gain;
        logic [GainW-1:0] integ_gain;
        logic [GainW-1:0] deriv_gain;
        logic [IlimW-1:0] integral_limit;
        logic [OlimW-1:0] output_limit;
        logic [GainW-1:0] speed_scale;
    } cfg_t;

    // control from the sequencer to the serial multiplier
    typedef struct packed {
        logic load;   // take new operands and start a product
        logic clear;  // start the sum from zero instead of adding on
    } mac_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FB,
        ST_ERR,
        ST_ACC,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/motor_speed_pid_step_unit.sv
// motor_speed_pid_step_unit: top level, positional pid with clamped integral
// depends on msps_pkg, msps_regs, msps_serial_mac
//
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_target_speed, s_measured_rpm, s_drive_enable
// m_        out        m_valid / m_ready    m_drive_value
// apb       in         psel, penable, ...   paddr, pwdata -> prdata, pready always high
//
// a transaction runs from acceptance to return to idle before a new
// one is accepted, in these steps:
// 4 products of 16 multiplier bits each in the shared bit-serial multiplier, plus
// error, integral clamp and output clamp steps
// the result register lets a new transaction in while the last result waits;
// a stalled m_ready holds the sequencer only in its final step
// synchronous active-low reset clears the config registers and pid state
`timescale 1ns / 1ps
`default_nettype none

module motor_speed_pid_step_unit import msps_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // input channel
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [SpeedW-1:0] s_target_speed,
    input  wire logic signed [SpeedW-1:0] s_measured_rpm,
    input  wire logic                     s_drive_enable,
    // result channel
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed      [SpeedW-1:0] m_drive_value,
    // configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic        [AddrW-1:0]  paddr,
    input  wire logic        [DataW-1:0]  pwdata,
    output logic             [DataW-1:0]  prdata,
    output logic                          pready
);

    cfg_t cfg;

    state_t state_reg;
    state_t state_next;

    // sample captured at acceptance
    logic signed [SpeedW-1:0] target_reg;
    logic                     enable_reg;

    // pid state and per-transaction terms
    logic signed [ErrW-1:0]   err_reg;
    logic signed [ErrW-1:0]   err_next;
    logic signed [ErrW-1:0]   prev_error_reg;
    logic signed [AccW-1:0]   accum_reg;
    logic signed [AccW-1:0]   accum_next;
    logic signed [DiffW-1:0]  diff_reg;
    logic signed [DiffW-1:0]  diff_next;

    // result register
    logic                     out_valid_reg;
    logic signed [SpeedW-1:0] out_data_reg;
    logic signed [SpeedW-1:0] out_data_next;
    logic                     out_load;

    // shared serial multiplier
    mac_ctrl_t                mac_ctrl;
    logic        [GainW-1:0]  mac_mplier;
    logic signed [OperW-1:0]  mac_mcand;
    logic signed [MacW-1:0]   mac_acc;
    logic                     mac_done;

    // combinational datapath terms
    logic signed [SpeedW-1:0] fdb;
    logic signed [AccW:0]     acc_sum;
    logic signed [AccW:0]     ilim_pos;
    logic signed [AccW:0]     ilim_neg;
    logic signed [ResW-1:0]   res;
    logic signed [ResW-1:0]   olim_pos;
    logic signed [ResW-1:0]   olim_neg;
    logic signed [ResW-1:0]   res_clamped;

    msps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msps_serial_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .mplier  (mac_mplier),
        .mcand   (mac_mcand),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid)  state_next = ST_MUL_FB;
            ST_MUL_FB: if (mac_done) state_next = ST_ERR;
            ST_ERR:                  state_next = ST_ACC;
            ST_ACC:                  state_next = ST_MUL_P;
            ST_MUL_P:  if (mac_done) state_next = ST_MUL_I;
            ST_MUL_I:  if (mac_done) state_next = ST_MUL_D;
            ST_MUL_D:  if (mac_done) state_next = ST_OUT;
            ST_OUT:    if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default:                 state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    // each product is loaded in the cycle that ends the step before it
    always_comb begin
        s_ready        = 1'b0;
        mac_ctrl.load  = 1'b0;
        mac_ctrl.clear = 1'b0;
        mac_mplier     = cfg.speed_scale;
        mac_mcand      = {{(OperW-SpeedW){s_measured_rpm[SpeedW-1]}}, s_measured_rpm};
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // rpm times speed scale
                s_ready        = 1'b1;
                mac_ctrl.load  = s_valid;
                mac_ctrl.clear = 1'b1;
            end
            ST_ACC: begin
                // proportional term starts a fresh sum
                mac_ctrl.load  = 1'b1;
                mac_ctrl.clear = 1'b1;
                mac_mplier     = cfg.prop_gain;
                mac_mcand      = {{(OperW-ErrW){err_reg[ErrW-1]}}, err_reg};
            end
            ST_MUL_P: begin
                // integral term on the clamped error sum
                mac_ctrl.load  = mac_done;
                mac_mplier     = cfg.integ_gain;
                mac_mcand      = accum_reg;
            end
            ST_MUL_I: begin
                // derivative term on the error difference
                mac_ctrl.load  = mac_done;
                mac_mplier     = cfg.deriv_gain;
                mac_mcand      = {{(OperW-DiffW){diff_reg[DiffW-1]}}, diff_reg};
            end
            ST_OUT: begin
                out_load = !out_valid_reg || m_ready;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // ---------------- datapath ----------------
    // feedback is floor(rpm * scale / 2^16): the upper half of the product
    assign fdb      = mac_acc[FbSh+SpeedW-1:FbSh];
    assign err_next = {{(ErrW-SpeedW){target_reg[SpeedW-1]}}, target_reg}
                    - {{(ErrW-SpeedW){fdb[SpeedW-1]}}, fdb};

    // integral clamp to plus or minus the limit
    assign acc_sum  = {accum_reg[AccW-1], accum_reg}
                    + {{(AccW+1-ErrW){err_reg[ErrW-1]}}, err_reg};
    assign ilim_pos = {{(AccW+1-IlimW){1'b0}}, cfg.integral_limit};
    assign ilim_neg = -ilim_pos;

    always_comb begin
        if (acc_sum > ilim_pos) begin
            accum_next = ilim_pos[AccW-1:0];
        end else if (acc_sum < ilim_neg) begin
            accum_next = ilim_neg[AccW-1:0];
        end else begin
            accum_next = acc_sum[AccW-1:0];
        end
    end

    assign diff_next = {err_reg[ErrW-1], err_reg}
                     - {prev_error_reg[ErrW-1], prev_error_reg};

    // drop the q8.8 fraction (floor), clamp to the output limit, zero when the drive is disabled
    assign res      = mac_acc[MacW-1:FracSh];
    assign olim_pos = {{(ResW-OlimW){1'b0}}, cfg.output_limit};
    assign olim_neg = -olim_pos;

    always_comb begin
        if (res > olim_pos) begin
            res_clamped = olim_pos;
        end else if (res < olim_neg) begin
            res_clamped = olim_neg;
        end else begin
            res_clamped = res;
        end
        out_data_next = enable_reg ? res_clamped[SpeedW-1:0] : '0;
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            prev_error_reg <= '0;
            accum_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_ACC) begin
                // pid state advances whether or not the drive is enabled
                accum_reg      <= accum_next;
                prev_error_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            target_reg <= s_target_speed;
            enable_reg <= s_drive_enable;
        end
        if (state_reg == ST_ERR) begin
            err_reg <= err_next;
        end
        if (state_reg == ST_ACC) begin
            diff_reg <= diff_next;
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_drive_value = out_data_reg;

endmodule

`default_nettype wire

FILE: hdl/msps_regs.sv
// msps_regs: apb-style configuration registers of the pid step unit
// depends on msps_pkg (cfg_t, reg_idx_t, widths)
`timescale 1ns / 1ps
`default_nettype none

module msps_regs import msps_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [DataW-1:0] pwdata,
    output logic      [DataW-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_PROP_GAIN:      cfg_next.prop_gain      = pwdata[GainW-1:0];
                REG_INTEG_GAIN:     cfg_next.integ_gain     = pwdata[GainW-1:0];
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = pwdata[GainW-1:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = pwdata[IlimW-1:0];
                REG_OUTPUT_LIMIT:   cfg_next.output_limit   = pwdata[OlimW-1:0];
                REG_SPEED_SCALE:    cfg_next.speed_scale    = pwdata[GainW-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PROP_GAIN:      prdata = DataW'(cfg_reg.prop_gain);
            REG_INTEG_GAIN:     prdata = DataW'(cfg_reg.integ_gain);
            REG_DERIV_GAIN:     prdata = DataW'(cfg_reg.deriv_gain);
            REG_INTEGRAL_LIMIT: prdata = DataW'(cfg_reg.integral_limit);
            REG_OUTPUT_LIMIT:   prdata = DataW'(cfg_reg.output_limit);
            REG_SPEED_SCALE:    prdata = DataW'(cfg_reg.speed_scale);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/msps_serial_mac.sv
// msps_serial_mac: bit-serial shift-add multiply-accumulate, one multiplier bit per cycle
// depends on msps_pkg (mac_ctrl_t, widths)
`timescale 1ns / 1ps
`default_nettype none

module msps_serial_mac import msps_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire mac_ctrl_t               ctrl,
    input  wire logic        [GainW-1:0] mplier,
    input  wire logic signed [OperW-1:0] mcand,
    output logic signed      [MacW-1:0]  acc,
    output logic                         done
);

    logic signed [MacW-1:0]  mcand_reg;
    logic signed [MacW-1:0]  mcand_next;
    logic        [GainW-1:0] mplier_reg;
    logic        [GainW-1:0] mplier_next;
    logic        [CntW-1:0]  count_reg;
    logic        [CntW-1:0]  count_next;
    logic signed [MacW-1:0]  acc_reg;
    logic signed [MacW-1:0]  acc_next;
    logic signed [MacW-1:0]  addend;
    logic                    busy;

    assign busy = (count_reg != '0);
    assign done = (count_reg == CntW'(1));
    assign acc  = acc_reg;

    always_comb begin
        addend      = (busy && mplier_reg[0]) ? mcand_reg : '0;
        acc_next    = acc_reg + addend;
        mcand_next  = mcand_reg <<< 1;
        mplier_next = mplier_reg >> 1;
        count_next  = busy ? (count_reg - CntW'(1)) : count_reg;
        if (ctrl.load) begin
            // a new product may start on the last step of the previous one
            mcand_next  = {{(MacW-OperW){mcand[OperW-1]}}, mcand};
            mplier_next = mplier;
            count_next  = CntW'(GainW);
            if (ctrl.clear) begin
                acc_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

endmodule

`default_nettype wire

FILE: hdl/msps_checker.sv
// msps_checker: port-level checks on the pid step unit, bound to its top level
// depends on msps_pkg (widths) and motor_speed_pid_step_unit
`timescale 1ns / 1ps
`default_nettype none

module msps_checker import msps_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [SpeedW-1:0] m_drive_value,
    input wire logic              pready
);

    // a waiting result is not withdrawn
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transaction completed");

    // a waiting result is not changed
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_drive_value))
        else $error("result changed while stalled");

    // one transaction at a time: input closes right after acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while busy");

    // a result only appears while an input transaction is in progress
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without work in progress");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port inserted wait state");

endmodule

bind motor_speed_pid_step_unit msps_checker u_checker (.*);

`default_nettype wire
